// ===== src/tct_pkg.sv =====
package tct_pkg;

  // request operation codes
  localparam logic [1:0] FUNC_REGISTER = 2'd0;
  localparam logic [1:0] FUNC_READ     = 2'd1;
  localparam logic [1:0] FUNC_WRITE    = 2'd2;
  localparam logic [1:0] FUNC_RELEASE  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  localparam int unsigned OwnerW = 63;
  localparam int unsigned WordW  = 64;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture request and restart the scan
    logic scan;  // read one owner entry and advance
    logic exec;  // apply the update and form the result
  } tct_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;  // current scan index is the last slot
  } tct_stat_t;

endpackage

// ===== src/tct_ctrl.sv =====
module tct_ctrl
  import tct_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  tct_stat_t stat_i,
  output tct_cmd_t  cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign busy_o = (state_q != S_IDLE) && (state_q != S_RESP);
  assign done_o = (state_q == S_RESP);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.load = accept;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        state_d = accept ? S_SCAN : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/tct_dpath.sv =====
module tct_dpath
  import tct_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tct_cmd_t          cmd_i,
  output tct_stat_t         stat_o,
  input  logic [1:0]        func_i,
  input  logic [OwnerW-1:0] owner_id_i,
  input  logic [WordW-1:0]  write_word_i,
  output logic [1:0]        status_o,
  output logic [WordW-1:0]  read_word_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [1:0]        func_q;
  logic [OwnerW-1:0] key_q;
  logic [WordW-1:0]  wword_q;

  logic [IW-1:0]     scan_idx_q;
  logic [IW-1:0]     cmp_idx_q;
  logic              cmp_vld_q;
  logic [OwnerW-1:0] owner_rd_q;

  logic              hit_found_q, free_found_q;
  logic [IW-1:0]     hit_idx_q, free_idx_q;

  logic [SLOTS-1:0]  valid_q;
  logic [OwnerW-1:0] owner_mem [SLOTS];
  logic [WordW-1:0]  word_mem [SLOTS];
  logic [WordW-1:0]  word_rd_q;

  logic [1:0]        status_q;
  logic              rd_sel_q;

  logic              entry_valid, entry_match;
  logic              do_claim, do_write, do_free;
  logic              word_we;
  logic [IW-1:0]     word_waddr;
  logic [WordW-1:0]  word_wdata;
  logic [1:0]        status_d;

  assign stat_o.scan_last = (scan_idx_q == IW'(SLOTS - 1));

  assign entry_valid = valid_q[cmp_idx_q];
  assign entry_match = entry_valid && (owner_rd_q == key_q);

  assign do_claim = cmd_i.exec && (func_q == FUNC_REGISTER) && !hit_found_q && free_found_q;
  assign do_write = cmd_i.exec && (func_q == FUNC_WRITE) && hit_found_q;
  assign do_free  = cmd_i.exec && (func_q == FUNC_RELEASE) && hit_found_q;

  assign word_we    = do_claim || do_write;
  assign word_waddr = do_claim ? free_idx_q : hit_idx_q;
  assign word_wdata = do_claim ? '0 : wword_q;

  always_comb begin
    unique case (func_q)
      FUNC_REGISTER: status_d = hit_found_q ? ST_DUP : (free_found_q ? ST_OK : ST_FULL);
      FUNC_READ,
      FUNC_WRITE:    status_d = hit_found_q ? ST_OK : ST_ABSENT;
      default:       status_d = ST_OK;
    endcase
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      key_q   <= owner_id_i;
      wword_q <= write_word_i;
    end
  end

  // scan control and first hit / first free tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q   <= '0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      hit_idx_q    <= '0;
      free_idx_q   <= '0;
    end else begin
      cmp_vld_q <= cmd_i.scan;
      if (cmd_i.scan) begin
        cmp_idx_q  <= scan_idx_q;
        scan_idx_q <= scan_idx_q + 1'b1;
      end
      if (cmd_i.load) begin
        scan_idx_q   <= '0;
        hit_found_q  <= 1'b0;
        free_found_q <= 1'b0;
      end else if (cmp_vld_q) begin
        if (entry_match && !hit_found_q) begin
          hit_found_q <= 1'b1;
          hit_idx_q   <= cmp_idx_q;
        end
        if (!entry_valid && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= cmp_idx_q;
        end
      end
    end
  end

  // slot valid marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (do_claim) valid_q[free_idx_q] <= 1'b1;
      if (do_free)  valid_q[hit_idx_q]  <= 1'b0;
    end
  end

  // owner store
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) owner_rd_q <= owner_mem[scan_idx_q];
    if (do_claim)   owner_mem[free_idx_q] <= key_q;
  end

  // data word store
  always_ff @(posedge clk_i) begin
    if (word_we)    word_mem[word_waddr] <= word_wdata;
    if (cmd_i.exec) word_rd_q <= word_mem[hit_idx_q];
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      rd_sel_q <= (func_q == FUNC_READ) && hit_found_q;
    end
  end

  assign status_o    = status_q;
  assign read_word_o = rd_sel_q ? word_rd_q : '0;

endmodule

// ===== src/thread_context_table.sv =====
// thread context table: SLOTS entries of {valid, 63-bit owner id, 64-bit data word}.
// a request (func, owner_id, write_word) is taken on a rising edge with start_i high
// and busy_o low. the block scans the owner store one slot per cycle from slot 0 up,
// then applies the update and presents one result beat on status_o/read_word_o with
// done_o high for exactly one cycle; the receiver cannot stall, so sample it then.
// after acceptance each request scans every slot, drains the compare stage, executes and
// then presents the result beat; busy_o drops during the result beat, so a new request may
// be accepted in that cycle. no clearing pass is needed after reset: valid marks reset
// at once and the stores are only read where valid.
module thread_context_table
  import tct_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request side
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        func_i,
  input  logic [OwnerW-1:0] owner_id_i,
  input  logic [WordW-1:0]  write_word_i,
  // result side, one beat per request
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [WordW-1:0]  read_word_o
);

  tct_cmd_t  cmd;
  tct_stat_t stat;

  // sequencer: scan, drain the compare stage, execute, respond
  tct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // slot stores, scan compare and result registers
  tct_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .func_i       (func_i),
    .owner_id_i   (owner_id_i),
    .write_word_i (write_word_i),
    .status_o     (status_o),
    .read_word_o  (read_word_o)
  );

`ifndef SYNTH
  // every result beat follows an execute cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd.exec))
    else $error("result beat without execute");

  // execute is always followed by exactly one result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> done_o)
    else $error("execute not followed by result beat");

  // an accepted request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not raise busy");

  // scanning and executing never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.scan && cmd.exec))
    else $error("scan and execute overlap");
`endif

endmodule

// ===== sim/thread_context_table_checker.sv =====
module thread_context_table_checker
  import tct_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_o,
  input  logic [1:0]        func_i,
  input  logic [OwnerW-1:0] owner_id_i,
  input  logic [WordW-1:0]  write_word_i,
  input  logic              done_o,
  input  logic [1:0]        status_o,
  input  logic [WordW-1:0]  read_word_o,
  output int                err_count_o,
  output int                replies_o
);

  typedef struct packed {
    logic [1:0]       status;
    logic [WordW-1:0] read_word;
  } reply_t;

  // shadow copy of the table
  logic              slot_valid [SLOTS];
  logic [OwnerW-1:0] slot_owner [SLOTS];
  logic [WordW-1:0]  slot_word  [SLOTS];

  reply_t reply_fifo [$];
  int     errors  = 0;
  int     replies = 0;

  assign err_count_o = errors;
  assign replies_o   = replies;

  task automatic apply_request(input logic [1:0] func, input logic [OwnerW-1:0] owner,
                               input logic [WordW-1:0] word, output reply_t reply);
    int hit;
    int free_slot;
    hit = -1;
    free_slot = -1;
    // walk downward so the lowest matching and lowest free slot win
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_owner[i] == owner) hit = i;
      if (!slot_valid[i]) free_slot = i;
    end
    reply.status = ST_OK;
    reply.read_word = '0;
    case (func)
      FUNC_REGISTER: begin
        if (hit >= 0) begin
          reply.status = ST_DUP;
        end else if (free_slot >= 0) begin
          slot_valid[free_slot] = 1'b1;
          slot_owner[free_slot] = owner;
          slot_word[free_slot]  = '0;
        end else begin
          reply.status = ST_FULL;
        end
      end
      FUNC_READ: begin
        if (hit >= 0) reply.read_word = slot_word[hit];
        else reply.status = ST_ABSENT;
      end
      FUNC_WRITE: begin
        if (hit >= 0) slot_word[hit] = word;
        else reply.status = ST_ABSENT;
      end
      default: begin
        // absent owner on release is silently ok
        if (hit >= 0) begin
          slot_valid[hit] = 1'b0;
          slot_word[hit]  = '0;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
      reply_fifo.delete();
    end else begin
      // result beat first: a new request may be taken in the same cycle
      if (done_o) begin
        replies++;
        if (reply_fifo.size() == 0) begin
          $error("unexpected result beat: status %0d read_word %h", status_o, read_word_o);
          errors++;
        end else begin
          want = reply_fifo.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            errors++;
          end
          if (read_word_o !== want.read_word) begin
            $error("read_word: expected %h, actual %h", want.read_word, read_word_o);
            errors++;
          end
        end
      end
      if (start_i && !busy_o) begin
        apply_request(func_i, owner_id_i, write_word_i, want);
        reply_fifo.push_back(want);
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import tct_pkg::*;

  localparam int unsigned SLOTS = 16;
  // owner pool a bit larger than the table so it fills up and hits dups
  localparam int unsigned POOL = 24;
  // worst case between beats is one full scan plus the longest idle gap that send adds, so this is generous
  localparam int IdleLimit = 1000;
  localparam int unsigned PhaseLen = 130;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start_i      = 1'b0;
  logic [1:0]        func_i       = FUNC_REGISTER;
  logic [OwnerW-1:0] owner_id_i   = '0;
  logic [WordW-1:0]  write_word_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [1:0]        status_o;
  logic [WordW-1:0]  read_word_o;

  int err_count;
  int replies;
  int issued      = 0;
  int idle_cycles = 0;
  bit quiet       = 1'b0;

  logic [OwnerW-1:0] owner_pool [POOL];
  int                reg_pct    [5] = '{70, 30, 90, 10, 50};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  thread_context_table #(
    .SLOTS(SLOTS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .owner_id_i  (owner_id_i),
    .write_word_i(write_word_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .read_word_o (read_word_o)
  );

  thread_context_table_checker #(
    .SLOTS(SLOTS)
  ) table_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .owner_id_i  (owner_id_i),
    .write_word_i(write_word_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .read_word_o (read_word_o),
    .err_count_o (err_count),
    .replies_o   (replies)
  );

  // watchdog: any request or result beat resets the count
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one request beat, hold it until taken, then maybe idle a while
  task automatic send(input logic [1:0] func, input logic [OwnerW-1:0] owner,
                      input logic [WordW-1:0] word);
    start_i      <= 1'b1;
    func_i       <= func;
    owner_id_i   <= owner;
    write_word_i <= word;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    issued++;
    if (!quiet && $urandom_range(99) < 35) begin
      start_i <= 1'b0;
      // half the gaps land after the result beat, when the block is idle,
      // the rest are swallowed by the scan of the request just taken
      if ($urandom_range(1)) begin
        @(posedge clk_i);
        while (!done_o) @(posedge clk_i);
      end
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [1:0]        func;
    logic [OwnerW-1:0] owner;
    logic [WordW-1:0]  word;
    int                pick;

    owner_pool[0] = '0;
    owner_pool[1] = '1;
    for (int i = 2; i < POOL; i++) owner_pool[i] = OwnerW'({$urandom, $urandom});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: basic life cycle of owner zero
    send(FUNC_REGISTER, '0, '1);
    send(FUNC_REGISTER, '0, '0);   // already registered
    send(FUNC_READ, '0, '1);       // freshly claimed word reads zero
    send(FUNC_WRITE, '0, '1);
    send(FUNC_READ, '0, '0);
    // absent owner on write, read and release
    send(FUNC_WRITE, '1, '1);
    send(FUNC_READ, '1, '0);
    send(FUNC_RELEASE, '1, '0);
    // fill the table, the last slot with the largest owner id
    for (int k = 1; k < SLOTS; k++) begin
      send(FUNC_REGISTER, (k == SLOTS - 1) ? {OwnerW{1'b1}} : OwnerW'(k), '0);
    end
    send(FUNC_REGISTER, {1'b1, {(OwnerW - 1){1'b0}}}, '1);   // table full
    send(FUNC_WRITE, {OwnerW{1'b1}}, {1'b1, {(WordW - 1){1'b0}}});
    send(FUNC_READ, {OwnerW{1'b1}}, '0);
    // free slot zero and reclaim it: its old word must be gone
    send(FUNC_RELEASE, '0, '0);
    send(FUNC_READ, '0, '0);
    send(FUNC_REGISTER, {1'b1, {(OwnerW - 1){1'b0}}}, '1);
    send(FUNC_READ, {1'b1, {(OwnerW - 1){1'b0}}}, '1);

    // random phases, each with its own register vs release balance so the
    // table swings between empty and full; the last phase runs with no gaps
    for (int ph = 0; ph < 5; ph++) begin
      quiet = (ph == 4);
      for (int n = 0; n < PhaseLen; n++) begin
        pick = $urandom_range(99);
        if (pick < reg_pct[ph] / 2) func = FUNC_REGISTER;
        else if (pick < 50) func = FUNC_RELEASE;
        else if (pick < 75) func = FUNC_READ;
        else func = FUNC_WRITE;
        // mostly known owners so requests hit; some stray ids for the misses
        if ($urandom_range(9) == 0) owner = OwnerW'({$urandom, $urandom});
        else owner = owner_pool[$urandom_range(POOL - 1)];
        pick = $urandom_range(9);
        if (pick == 0) word = '0;
        else if (pick == 1) word = '1;
        else word = {$urandom, $urandom};
        send(func, owner, word);
      end
    end

    start_i <= 1'b0;
    wait (replies == issued);
    repeat (25) @(posedge clk_i);
    if (err_count == 0 && replies == issued) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
